// ===== src/urdi_pkg.sv =====
// ----------------------------------------------------------------------------
// urdi_pkg
// Shared sizes, types and codes of the row deduplication index.
// ----------------------------------------------------------------------------
`default_nettype none

package urdi_pkg;

  localparam int TABLE_ROWS  = 64;
  localparam int KEY_COLUMNS = 4;
  localparam int KEY_BITS    = 32;
  localparam int IN_KEYS     = 4;   // key columns carried by one beat
  localparam int FIELD_W     = 32;  // width of one key column port
  localparam int LANES       = 8;   // compare lanes, power of two

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int GROUPS = (TABLE_ROWS + LANES - 1) / LANES;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
  localparam int ROW_W  = GRP_W + LANE_W;
  localparam int CMP_W  = ((ROW_W > CNT_W) ? ROW_W : CNT_W) + 1;
  localparam int MAX_ACT = (KEY_COLUMNS < IN_KEYS) ? KEY_COLUMNS : IN_KEYS;

  localparam int IDX_W  = 7;
  localparam int COLS_W = 3;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(4);

  // Register index, taken from paddr[2]
  localparam logic REG_COLS = 1'b0;

  typedef logic [KEY_COLUMNS-1:0][KEY_BITS-1:0] key_row_t;
  typedef logic [KEY_COLUMNS-1:0]               col_mask_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } merge_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_APPEND,
    S_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== src/urdi_ram.sv =====
// ----------------------------------------------------------------------------
// urdi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module urdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/urdi_lane.sv =====
// ----------------------------------------------------------------------------
// urdi_lane
// One compare lane: matches a stored row against the key on active columns.
// ----------------------------------------------------------------------------
`default_nettype none

module urdi_lane
  import urdi_pkg::*;
(
  input  wire key_row_t  row_i,
  input  wire key_row_t  key_i,
  input  wire col_mask_t col_en_i,
  input  wire logic      live_i,   // row lies below the fill count
  output      logic      hit_o
);

  col_mask_t col_ok;

  always_comb begin
    for (int j = 0; j < KEY_COLUMNS; j++) begin
      col_ok[j] = !col_en_i[j] || (row_i[j] == key_i[j]);
    end
  end

  assign hit_o = live_i && (&col_ok);

endmodule

`default_nettype wire

// ===== src/urdi_merge.sv =====
// ----------------------------------------------------------------------------
// urdi_merge
// Merges lane hits: lowest-numbered matching lane wins (earliest row).
// ----------------------------------------------------------------------------
`default_nettype none

module urdi_merge
  import urdi_pkg::*;
(
  input  wire logic [LANES-1:0] hits_i,
  output      merge_t           merge_o
);

  always_comb begin
    merge_o = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hits_i[l]) begin
        merge_o.hit  = 1'b1;
        merge_o.lane = LANE_W'(l);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/unique_row_dedup_index.sv =====
// ----------------------------------------------------------------------------
// unique_row_dedup_index
// First-occurrence deduplication table for four-column key rows.
// ----------------------------------------------------------------------------
// Each input beat carries one row of four 32-bit keys. The row is looked up
// among the distinct rows stored so far, compared on the leading
// columns_in_use columns (a value of 0 acts as 1, above 4 as 4). A match
// returns the one-based index of the earliest identical row; otherwise the
// row is appended and gets the next index. first_row empties the table before
// the row is handled. With the table full (64 rows) an unmatched row gives
// overflow, index 0 and distinct_count 64. The table sits in eight RAM banks,
// one per compare lane, row r living in bank r mod 8 at word r / 8. One read
// of all banks checks a group of eight rows at once; a merge stage picks the
// lowest matching lane. Timing: one item at a time. After acceptance the item
// goes through a bank read and a compare per group of eight stored rows
// scanned, an append step if it is appended or overflows, and a step that
// moves it to the output register, paced by the single read port of each
// bank. A new row is taken while an earlier result still waits on a stalled
// output. No clearing pass is needed after reset: the fill count keeps
// unwritten words out of every compare.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_row_dedup_index
  import urdi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // APB configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output      logic [APB_DW-1:0]   prdata,
  output      logic                pready,

  // Input rows
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                first_row_i,
  input  wire logic [FIELD_W-1:0]  key_col0_i,
  input  wire logic [FIELD_W-1:0]  key_col1_i,
  input  wire logic [FIELD_W-1:0]  key_col2_i,
  input  wire logic [FIELD_W-1:0]  key_col3_i,

  // Results
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [IDX_W-1:0]    row_index_o,
  output      logic                is_new_o,
  output      logic [IDX_W-1:0]    distinct_count_o,
  output      logic                overflow_o
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [COLS_W-1:0] cols_q, cols_d;
  logic              cfg_wr;
  logic [COLS_W-1:0] ncmp;
  col_mask_t         col_en;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COLS);
  assign cols_d = cfg_wr ? pwdata[COLS_W-1:0] : cols_q;
  assign prdata = (paddr[2] == REG_COLS) ? APB_DW'(cols_q) : '0;

  // Clamp the column count to 1..MAX_ACT
  always_comb begin
    ncmp = cols_q;
    if (ncmp == '0) begin
      ncmp = COLS_W'(1);
    end
    if (32'(ncmp) > MAX_ACT) begin
      ncmp = COLS_W'(MAX_ACT);
    end
    for (int j = 0; j < KEY_COLUMNS; j++) begin
      col_en[j] = (32'(j) < 32'(ncmp));
    end
  end

  // --------------------------------------------------------------------------
  // Key capture
  // --------------------------------------------------------------------------
  logic [FIELD_W-1:0] col_in [IN_KEYS];
  key_row_t           key_in;
  key_row_t           key_q;

  assign col_in[0] = key_col0_i;
  assign col_in[1] = key_col1_i;
  assign col_in[2] = key_col2_i;
  assign col_in[3] = key_col3_i;

  for (genvar j = 0; j < KEY_COLUMNS; j++) begin : g_key
    if (j < IN_KEYS) begin : g_in
      assign key_in[j] = KEY_BITS'(col_in[j]);
    end else begin : g_zero
      assign key_in[j] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   next_start;
  logic               in_acc;
  logic               out_free;
  logic               full;
  logic               last_grp;
  logic               cnt_zero_after;
  merge_t             merge;

  assign in_acc         = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_o || !out_stall_i;
  assign cnt_ext        = CMP_W'(count_q);
  assign full           = (count_q == CNT_W'(TABLE_ROWS));
  assign next_start     = CMP_W'({grp_q, LANE_W'(0)}) + CMP_W'(LANES);
  assign last_grp       = (next_start >= cnt_ext);
  assign cnt_zero_after = first_row_i || (count_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = cnt_zero_after ? S_APPEND : S_READ;
        end
      end
      S_READ:   state_d = S_CMP;
      S_CMP: begin
        if (merge.hit) begin
          state_d = S_OUT;
        end else if (last_grp) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_READ;
        end
      end
      S_APPEND: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // State outputs
  logic rd_en;
  logic wr_en;
  logic grp_step;
  logic out_load;

  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    grp_step   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:   in_stall_o = 1'b0;
      S_READ:   rd_en      = 1'b1;
      S_CMP:    grp_step   = !merge.hit && !last_grp;
      S_APPEND: wr_en      = !full;
      S_OUT:    out_load   = out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (in_acc && first_row_i) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    grp_d = grp_q;
    if (in_acc) begin
      grp_d = '0;
    end else if (grp_step) begin
      grp_d = grp_q + GRP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      grp_q   <= '0;
      cols_q  <= COLS_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      grp_q   <= grp_d;
      cols_q  <= cols_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= key_in;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: one bank and one comparator each
  // --------------------------------------------------------------------------
  logic [LANES-1:0] hits;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    key_row_t          rd_row;
    logic [CMP_W-1:0]  row_num;
    logic              bank_we;

    assign bank_we = wr_en && (cnt_ext[LANE_W-1:0] == LANE_W'(l));
    assign row_num = CMP_W'({grp_q, LANE_W'(l)});

    urdi_ram #(
      .WIDTH ($bits(key_row_t)),
      .DEPTH (GROUPS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (cnt_ext[LANE_W +: GRP_W]),
      .wdata_i (key_q),
      .re_i    (rd_en),
      .raddr_i (grp_q),
      .rdata_o (rd_row)
    );

    urdi_lane u_lane (
      .row_i    (rd_row),
      .key_i    (key_q),
      .col_en_i (col_en),
      .live_i   (row_num < cnt_ext),
      .hit_o    (hits[l])
    );
  end

  urdi_merge u_merge (
    .hits_i  (hits),
    .merge_o (merge)
  );

  // --------------------------------------------------------------------------
  // Result and output register
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] res_idx_q;
  logic             res_new_q;
  logic             res_ovf_q;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] row_index_q;
  logic             is_new_q;
  logic [IDX_W-1:0] distinct_count_q;
  logic             overflow_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CMP && merge.hit) begin
      res_idx_q <= IDX_W'(CMP_W'({grp_q, merge.lane}) + CMP_W'(1));
      res_new_q <= 1'b0;
      res_ovf_q <= 1'b0;
    end else if (state_q == S_APPEND) begin
      res_idx_q <= full ? '0 : IDX_W'(cnt_ext + CMP_W'(1));
      res_new_q <= !full;
      res_ovf_q <= full;
    end
    if (out_load) begin
      row_index_q      <= res_idx_q;
      is_new_q         <= res_new_q;
      overflow_q       <= res_ovf_q;
      distinct_count_q <= IDX_W'(count_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_index_o      = row_index_q;
  assign is_new_o         = is_new_q;
  assign distinct_count_o = distinct_count_q;
  assign overflow_o       = overflow_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ROWS))
    else $error("fill count beyond table size");

  a_append_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not advance fill count");

  a_new_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_new_o) |-> (row_index_o == distinct_count_o) && !overflow_o)
    else $error("new row index differs from distinct count");

  a_overflow_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |->
      (row_index_o == '0) && !is_new_o && (distinct_count_o == IDX_W'(TABLE_ROWS)))
    else $error("inconsistent overflow beat");

endmodule

`default_nettype wire
